// ===== hdl/lljd_pkg.sv =====
// Shared types and constants for the least loaded job dispatcher.
package lljd_pkg;

	// Default build parameters
	localparam int DEF_WORKERS   = 16;
	localparam int DEF_TIME_BITS = 48;

	// Field widths fixed by the stream format
	localparam int DUR_W   = 32;
	localparam int ID_W    = 4;
	localparam int START_W = 48;
	localparam int TDATA_IN_W  = 32;
	localparam int TDATA_OUT_W = 56;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int NW_W    = 5;
	localparam logic [0:0] REG_NUM_WORKERS = 1'b0;
	localparam logic [NW_W-1:0] NUM_WORKERS_RST = 5'd16;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	// One dispatch result as handed from the core to the output stage
	typedef struct packed {
		logic [START_W-1:0] start_time;
		logic [ID_W-1:0]    worker_id;
	} result_t;

endpackage

// ===== hdl/lljd_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module lljd_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/lljd_core.sv =====
// Scan sequencer: clears the free-time store, finds the earliest free worker, updates it.
module lljd_core #(
	parameter int WORKERS   = lljd_pkg::DEF_WORKERS,
	parameter int TIME_BITS = lljd_pkg::DEF_TIME_BITS,
	localparam int IW = (WORKERS > 1) ? $clog2(WORKERS) : 1,
	localparam int CW = $clog2(WORKERS + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       ready,
	input  logic [lljd_pkg::DUR_W-1:0] dur,
	input  logic [CW-1:0]              n_act,
	input  logic                       out_free,
	output logic                       res_valid,
	output lljd_pkg::result_t          res
);

	lljd_pkg::state_t state_q, state_d;

	logic [IW-1:0]        clr_idx_q;
	logic [CW-1:0]        rd_idx_q;
	logic [CW-1:0]        n_q;
	logic                 rd_vld_s1;
	logic [IW-1:0]        rd_idx_s1;
	logic [TIME_BITS-1:0] best_q;
	logic [IW-1:0]        best_idx_q;
	logic [lljd_pkg::DUR_W-1:0] dur_q;

	logic                 issue;
	logic                 scan_done;
	logic                 ram_we;
	logic [IW-1:0]        ram_waddr;
	logic [TIME_BITS-1:0] ram_wdata;
	logic [TIME_BITS-1:0] ram_rdata;
	logic [TIME_BITS:0]   sum;
	logic [TIME_BITS-1:0] sat_sum;

	lljd_ram #(
		.WIDTH(TIME_BITS),
		.DEPTH(WORKERS)
	) u_free_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_idx_q[IW-1:0]),
		.rdata(ram_rdata)
	);

	// Read issue and end of scan
	assign issue     = (state_q == lljd_pkg::ST_SCAN) && (rd_idx_q < n_q);
	assign scan_done = rd_vld_s1 && (CW'(rd_idx_s1) == (n_q - CW'(1)));

	// Saturating add of the job duration to the chosen free time
	assign sum     = {1'b0, best_q} + (TIME_BITS+1)'(dur_q);
	assign sat_sum = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lljd_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and store access
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = clr_idx_q;
		ram_wdata = '0;
		res_valid = 1'b0;
		ready     = 1'b0;
		unique case (state_q)
			lljd_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				if (clr_idx_q == IW'(WORKERS - 1)) begin
					state_d = lljd_pkg::ST_IDLE;
				end
			end
			lljd_pkg::ST_IDLE: begin
				ready = 1'b1;
				if (start) begin
					state_d = lljd_pkg::ST_SCAN;
				end
			end
			lljd_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = lljd_pkg::ST_UPDATE;
				end
			end
			lljd_pkg::ST_UPDATE: begin
				ram_waddr = best_idx_q;
				ram_wdata = sat_sum;
				if (out_free) begin
					ram_we    = 1'b1;
					res_valid = 1'b1;
					state_d   = lljd_pkg::ST_IDLE;
				end
			end
			default: state_d = lljd_pkg::ST_IDLE;
		endcase
	end

	// Control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (state_q == lljd_pkg::ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + IW'(1);
			end
			if (state_q == lljd_pkg::ST_IDLE) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			rd_vld_s1 <= issue;
		end
	end

	// Job payload and running minimum
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx_q[IW-1:0];
		if (state_q == lljd_pkg::ST_IDLE && start) begin
			dur_q <= dur;
			n_q   <= n_act;
		end
		if (rd_vld_s1 && (rd_idx_s1 == '0 || ram_rdata < best_q)) begin
			best_q     <= ram_rdata;
			best_idx_q <= rd_idx_s1;
		end
	end

	assign res.worker_id  = lljd_pkg::ID_W'(best_idx_q);
	assign res.start_time = lljd_pkg::START_W'(best_q);

	// Every compared entry lies inside the active worker range
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (CW'(rd_idx_s1) < n_q))
		else $error("scan compared a worker outside the active range");

	// The store is never written while the scan reads it
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lljd_pkg::ST_SCAN) |-> !ram_we)
		else $error("free-time store written during scan");

	// One result per job: a result is never followed directly by another
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> !res_valid)
		else $error("back to back results from one job");

	// An accepted job starts the scan
	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(ready && start) |=> (state_q == lljd_pkg::ST_SCAN))
		else $error("accepted job did not start a scan");

endmodule

// ===== hdl/least_loaded_job_dispatcher.sv =====
// Least loaded job dispatcher top level: stream ports, register port, output stage.
//
// Each transfer on the s_ side carries one job duration. The block picks the
// worker that becomes free earliest (lowest number on ties), among the first
// num_workers workers, and returns one m_ side transfer with that worker's
// number and the job's start time; the worker's free time then advances by the
// duration, saturating at the largest TIME_BITS-bit value.
// Each job passes from the idle state through the scan to the update, which
// loads the result into the output register; the scan reads the free-time
// store of the n active workers, one RAM read per cycle.
// s_tready is high only while the sequencer is idle, one job at a time, so a
// new job is taken only after the previous one has left the update state.
// After reset the free-time store is cleared with s_tready low; num_workers
// resets to 16. Register writes are taken at any time.
// If the receiver stalls, a result waits in the output register; the next job
// is still accepted and scanned, and holds at its update until the register
// frees up.
module least_loaded_job_dispatcher #(
	parameter int WORKERS   = lljd_pkg::DEF_WORKERS,
	parameter int TIME_BITS = lljd_pkg::DEF_TIME_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// job_duration[31:0]
	input  logic [lljd_pkg::TDATA_IN_W-1:0]  s_tdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// worker_id[3:0], start_time[51:4], zero pad[55:52]
	output logic [lljd_pkg::TDATA_OUT_W-1:0] m_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lljd_pkg::PADDR_W-1:0]     paddr,
	input  logic [lljd_pkg::PDATA_W-1:0]     pwdata,
	output logic [lljd_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready
);

	localparam int CW = $clog2(WORKERS + 1);

	logic [lljd_pkg::NW_W-1:0] num_workers_q;
	logic [CW-1:0]             n_act;
	logic                      reg_sel;
	logic                      core_ready;
	logic                      out_free;
	logic                      res_valid;
	lljd_pkg::result_t         res;
	logic                      m_tvalid_q;
	lljd_pkg::result_t         m_res_q;

	// Register decode: word index sits in paddr[2]
	assign reg_sel = (paddr[2] == lljd_pkg::REG_NUM_WORKERS);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? lljd_pkg::PDATA_W'(num_workers_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_workers_q <= lljd_pkg::NUM_WORKERS_RST;
		end else if (psel && penable && pwrite && reg_sel) begin
			num_workers_q <= pwdata[lljd_pkg::NW_W-1:0];
		end
	end

	// Clamp the worker count to 1..WORKERS
	always_comb begin
		if (num_workers_q == '0) begin
			n_act = CW'(1);
		end else if (32'(num_workers_q) > WORKERS) begin
			n_act = CW'(WORKERS);
		end else begin
			n_act = CW'(num_workers_q);
		end
	end

	lljd_core #(
		.WORKERS  (WORKERS),
		.TIME_BITS(TIME_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_tvalid),
		.ready    (core_ready),
		.dur      (s_tdata),
		.n_act    (n_act),
		.out_free (out_free),
		.res_valid(res_valid),
		.res      (res)
	);

	assign s_tready = core_ready;

	// Output register: load a result when empty or being drained
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = lljd_pkg::TDATA_OUT_W'(m_res_q);

endmodule
